// ===== design/cfe_pkg.sv =====
// Shared constants for the COBS frame encoder.
package cfe_pkg;

   localparam int CSR_WIDTH = 13;
   localparam logic [CSR_WIDTH-1:0] CSR_RESET = 13'd512;

   localparam int MAX_RESULTS = 4;
   localparam int IDX_W = $clog2(MAX_RESULTS);
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CODE_FULL = 8'hFF;
   localparam logic [7:0] CODE_START = 8'h01;
   localparam logic [7:0] DELIMITER = 8'h00;

endpackage

// ===== design/cobs_frame_encoder.sv =====
// COBS frame encoder top level: front end, result queue and back end.
//
//   channel   ports                        accepted when
//   req       req_push / req_full          req_push && !req_full
//   rsp       rsp_pop / rsp_empty          rsp_pop && !rsp_empty
//   csr       csr_write_enable / data      csr_write_enable
//
// One input word is taken per cycle while the result queue has room.
// The back end sends one result per cycle while results wait and the receiver pops; a
// word makes 0 to 4 results, so the extra results of a group close or frame end are
// absorbed by the 4-entry queue. A word's first result passes the queue and then the output register.
// Synchronous reset clears frame state and empties the queue and output register;
// capacity returns to 512. A stalled output side fills the queue and then raises req_full.
module cobs_frame_encoder #(
   parameter int ADDRESS_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_has_byte,
   input  logic                          req_frame_end,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [ADDRESS_BITS-1:0]       rsp_write_address,
   output logic [7:0]                    rsp_write_byte,
   output logic                          rsp_frame_done,
   output logic                          rsp_overflow,
   output logic                          rsp_last_result,
   input  logic                          csr_write_enable,
   input  logic [cfe_pkg::CSR_WIDTH-1:0] csr_write_data
);
   import cfe_pkg::*;

   localparam int ENTRY_W = MAX_RESULTS * (ADDRESS_BITS + 10) + IDX_W;

   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   logic [ENTRY_W-1:0] q_entry;
   logic [ENTRY_W-1:0] q_head;

   cfe_front #(
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_push        (req_push),
      .req_data_byte   (req_data_byte),
      .req_has_byte    (req_has_byte),
      .req_frame_end   (req_frame_end),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   cfe_queue #(
      .WIDTH(ENTRY_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_entry),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   cfe_back #(
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_head           (q_head),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_write_address(rsp_write_address),
      .rsp_write_byte   (rsp_write_byte),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_overflow     (rsp_overflow),
      .rsp_last_result  (rsp_last_result)
   );

   assign req_full = q_full;

endmodule

// ===== design/cfe_front.sv =====
// Front end: frame state, capacity check and per-word result list.
module cfe_front #(
   parameter int ADDRESS_BITS = 12,
   localparam int ENTRY_W = cfe_pkg::MAX_RESULTS * (ADDRESS_BITS + 10) + cfe_pkg::IDX_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [cfe_pkg::CSR_WIDTH-1:0]   csr_write_data,
   input  logic                            req_push,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_has_byte,
   input  logic                            req_frame_end,
   input  logic                            q_full,
   output logic                            q_push,
   output logic [ENTRY_W-1:0]              q_entry
);
   import cfe_pkg::*;

   localparam int POS_W = ADDRESS_BITS + 1;
   localparam int CAP_W = (POS_W > CSR_WIDTH) ? POS_W : CSR_WIDTH;

   typedef struct packed {
      logic [ADDRESS_BITS-1:0] addr;
      logic [7:0]              data;
      logic                    done;
      logic                    ovf;
   } res_type;

   typedef struct packed {
      res_type [MAX_RESULTS-1:0] res;
      logic [IDX_W-1:0]          last_idx;
   } entry_type;

   logic [CSR_WIDTH-1:0]    capacity_ff, capacity_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [ADDRESS_BITS-1:0] code_pos_ff, code_pos_in;
   logic [7:0]              group_code_ff, group_code_in;
   logic                    aborted_ff, aborted_in;

   logic [CAP_W-1:0] cap_limit;
   logic [CAP_W-1:0] cap;
   logic             accept;
   entry_type        entry;
   logic [CNT_W-1:0] n_results;

   assign cap_limit = CAP_W'(1) << ADDRESS_BITS;
   assign cap = (CAP_W'(capacity_ff) > cap_limit) ? cap_limit : CAP_W'(capacity_ff);
   assign accept = req_push && !q_full;

   assign capacity_in = csr_write_enable ? csr_write_data : capacity_ff;

   always_comb begin
      logic [POS_W-1:0]        p;
      logic [ADDRESS_BITS-1:0] cp;
      logic [7:0]              gc;
      logic                    ab;
      logic                    stop;
      logic                    restart;
      logic [CNT_W-1:0]        n;

      entry = '0;
      n = '0;
      p = pos_ff;
      cp = code_pos_ff;
      gc = group_code_ff;
      ab = aborted_ff;
      stop = 1'b0;
      restart = 1'b0;

      if (aborted_ff) begin
         restart = req_frame_end;
      end else if (req_has_byte || req_frame_end) begin
         if (CAP_W'(p) >= cap) begin
            entry.res[n[IDX_W-1:0]].ovf = 1'b1;
            n = n + CNT_W'(1);
            ab = 1'b1;
            stop = 1'b1;
         end
         if (!stop && req_has_byte) begin
            if (req_data_byte == 8'h00) begin
               entry.res[n[IDX_W-1:0]].addr = cp;
               entry.res[n[IDX_W-1:0]].data = gc;
               n = n + CNT_W'(1);
               cp = p[ADDRESS_BITS-1:0];
               p = p + POS_W'(1);
               gc = CODE_START;
               if (CAP_W'(p) >= cap) begin
                  entry.res[n[IDX_W-1:0]].ovf = 1'b1;
                  n = n + CNT_W'(1);
                  ab = 1'b1;
                  stop = 1'b1;
               end
            end else begin
               entry.res[n[IDX_W-1:0]].addr = p[ADDRESS_BITS-1:0];
               entry.res[n[IDX_W-1:0]].data = req_data_byte;
               n = n + CNT_W'(1);
               p = p + POS_W'(1);
               gc = gc + 8'd1;
               // full group: patch its code and open the next one
               if (gc == CODE_FULL) begin
                  entry.res[n[IDX_W-1:0]].addr = cp;
                  entry.res[n[IDX_W-1:0]].data = CODE_FULL;
                  n = n + CNT_W'(1);
                  cp = p[ADDRESS_BITS-1:0];
                  p = p + POS_W'(1);
                  gc = CODE_START;
                  if (CAP_W'(p) >= cap) begin
                     entry.res[n[IDX_W-1:0]].ovf = 1'b1;
                     n = n + CNT_W'(1);
                     ab = 1'b1;
                     stop = 1'b1;
                  end
               end
            end
         end
         if (!stop && req_frame_end) begin
            entry.res[n[IDX_W-1:0]].addr = cp;
            entry.res[n[IDX_W-1:0]].data = gc;
            n = n + CNT_W'(1);
            if (CAP_W'(p) >= cap) begin
               entry.res[n[IDX_W-1:0]].ovf = 1'b1;
               n = n + CNT_W'(1);
               ab = 1'b1;
            end else begin
               entry.res[n[IDX_W-1:0]].addr = p[ADDRESS_BITS-1:0];
               entry.res[n[IDX_W-1:0]].data = DELIMITER;
               entry.res[n[IDX_W-1:0]].done = 1'b1;
               n = n + CNT_W'(1);
               restart = 1'b1;
            end
         end
         if (req_frame_end && ab) begin
            restart = 1'b1;
         end
      end

      if (restart) begin
         p = POS_W'(1);
         cp = '0;
         gc = CODE_START;
         ab = 1'b0;
      end

      if (n != '0) begin
         entry.last_idx = IDX_W'(n - CNT_W'(1));
      end
      n_results = n;

      pos_in        = accept ? p  : pos_ff;
      code_pos_in   = accept ? cp : code_pos_ff;
      group_code_in = accept ? gc : group_code_ff;
      aborted_in    = accept ? ab : aborted_ff;
   end

   assign q_push = accept && (n_results != '0);
   assign q_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CSR_RESET;
         pos_ff        <= POS_W'(1);
         code_pos_ff   <= '0;
         group_code_ff <= CODE_START;
         aborted_ff    <= 1'b0;
      end else begin
         capacity_ff   <= capacity_in;
         pos_ff        <= pos_in;
         code_pos_ff   <= code_pos_in;
         group_code_ff <= group_code_in;
         aborted_ff    <= aborted_in;
      end
   end

   // an aborted frame drops every word until its end
   a_aborted_silent: assert property (@(posedge clock) disable iff (reset)
      aborted_ff |-> !q_push)
      else $error("front pushed results while frame aborted");

endmodule

// ===== design/cfe_queue.sv =====
// Short queue of result lists between the front and back ends.
module cfe_queue #(
   parameter int WIDTH = 90
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             full,
   output logic             empty
);
   import cfe_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]   store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W_Q'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W_Q'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

endmodule

// ===== design/cfe_back.sv =====
// Back end: walk each queued result list into the output register.
module cfe_back #(
   parameter int ADDRESS_BITS = 12,
   localparam int ENTRY_W = cfe_pkg::MAX_RESULTS * (ADDRESS_BITS + 10) + cfe_pkg::IDX_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [ENTRY_W-1:0]      q_head,
   input  logic                    q_empty,
   output logic                    q_pop,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output logic [ADDRESS_BITS-1:0] rsp_write_address,
   output logic [7:0]              rsp_write_byte,
   output logic                    rsp_frame_done,
   output logic                    rsp_overflow,
   output logic                    rsp_last_result
);
   import cfe_pkg::*;

   typedef struct packed {
      logic [ADDRESS_BITS-1:0] addr;
      logic [7:0]              data;
      logic                    done;
      logic                    ovf;
   } res_type;

   typedef struct packed {
      res_type [MAX_RESULTS-1:0] res;
      logic [IDX_W-1:0]          last_idx;
   } entry_type;

   entry_type        head;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   res_type          out_res_ff, out_res_in;
   logic             out_last_ff, out_last_in;
   logic             advance;
   logic             load;
   logic             at_last;

   assign head    = q_head;
   assign advance = !out_valid_ff || rsp_pop;
   assign load    = advance && !q_empty;
   assign at_last = (idx_ff == head.last_idx);
   assign q_pop   = load && at_last;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      out_last_in  = out_last_ff;
      idx_in       = idx_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_res_in   = head.res[idx_ff];
         out_last_in  = at_last;
         idx_in       = at_last ? '0 : idx_ff + IDX_W'(1);
      end else if (advance) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_write_address = out_res_ff.addr;
   assign rsp_write_byte    = out_res_ff.data;
   assign rsp_frame_done    = out_res_ff.done;
   assign rsp_overflow      = out_res_ff.ovf;
   assign rsp_last_result   = out_last_ff;

   // finishing a list rewinds the index for the next one
   a_index_rewind: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> idx_ff == '0)
      else $error("result index not rewound after list");

endmodule

// ===== sim/cobs_frame_encoder_test.sv =====
// Self-checking testbench for the COBS frame encoder against a buffer-write predictor.
module cobs_frame_encoder_test;
   import cfe_pkg::*;

   localparam int ADDR_W = 12;
   localparam int CLOCK_HALF = 6;
   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASES = 12;
   localparam int PHASE_WORDS = 6;
   localparam logic [12:0] ADDR_SPACE = 13'd4096;

   typedef struct {
      logic [ADDR_W-1:0] address;
      logic [7:0]        value;
      logic              done;
      logic              overflow;
      logic              last;
   } buf_write_type;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   class cobs_write_board;
      logic [CSR_WIDTH-1:0] capacity;
      logic [12:0]          next_pos;
      logic [ADDR_W-1:0]    code_pos;
      logic [7:0]           group_code;
      bit                   aborted;
      buf_write_type        pending[$];
      int                   failures;

      function new();
         capacity = CSR_RESET;
         failures = 0;
         restart();
      endfunction

      function void restart();
         next_pos = 13'd1;
         code_pos = '0;
         group_code = CODE_START;
         aborted = 0;
      endfunction

      function void add(logic [12:0] address, logic [7:0] value, bit done, bit overflow);
         buf_write_type w;
         w.address = address[ADDR_W-1:0];
         w.value = value;
         w.done = done;
         w.overflow = overflow;
         w.last = 0;
         pending.push_back(w);
      endfunction

      function bit out_of_room();
         logic [12:0] room;
         room = (capacity > ADDR_SPACE) ? ADDR_SPACE : capacity;
         if (next_pos >= room) begin
            add('0, '0, 0, 1);
            aborted = 1;
            return 1;
         end
         return 0;
      endfunction

      function void close_group();
         add({1'b0, code_pos}, group_code, 0, 0);
         code_pos = next_pos[ADDR_W-1:0];
         next_pos = next_pos + 13'd1;
         group_code = CODE_START;
      endfunction

      // Predict the buffer writes caused by one accepted word.
      function void note_word(logic [7:0] data, bit has, bit fin);
         int first;
         bit stop;
         first = pending.size();
         if (aborted) begin
            if (fin)
               restart();
            return;
         end
         if (!has && !fin)
            return;
         stop = out_of_room();
         if (!stop && has) begin
            if (data == 8'h00) begin
               close_group();
               stop = out_of_room();
            end else begin
               add(next_pos, data, 0, 0);
               next_pos = next_pos + 13'd1;
               group_code = group_code + 8'd1;
               if (group_code == CODE_FULL) begin
                  close_group();
                  stop = out_of_room();
               end
            end
         end
         if (!stop && fin) begin
            add({1'b0, code_pos}, group_code, 0, 0);
            stop = out_of_room();
            if (!stop) begin
               add(next_pos, DELIMITER, 1, 0);
               restart();
            end
         end
         if (fin && aborted)
            restart();
         if (pending.size() > first)
            pending[pending.size() - 1].last = 1;
      endfunction

      function void check(logic [ADDR_W-1:0] address, logic [7:0] value, logic done,
                          logic overflow, logic last);
         buf_write_type want;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: extra write addr %03h byte %02h done %b ovf %b last %b",
                        $realtime, address, value, done, overflow, last);
            return;
         end
         want = pending.pop_front();
         if (want.address !== address || want.value !== value || want.done !== done ||
             want.overflow !== overflow || want.last !== last) begin
            failures++;
            if (failures <= 10)
               $display({"%0t: want addr %03h byte %02h done %b ovf %b last %b,",
                         " got %03h %02h %b %b %b"},
                        $realtime, want.address, want.value, want.done, want.overflow,
                        want.last, address, value, done, overflow, last);
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_push;
   logic                    req_full;
   logic [7:0]              req_data_byte;
   logic                    req_has_byte;
   logic                    req_frame_end;
   logic                    rsp_empty;
   logic                    rsp_pop;
   logic [ADDR_W-1:0]       rsp_write_address;
   logic [7:0]              rsp_write_byte;
   logic                    rsp_frame_done;
   logic                    rsp_overflow;
   logic                    rsp_last_result;
   logic                    csr_write_enable;
   logic [CSR_WIDTH-1:0]    csr_write_data;

   cobs_write_board board;
   idle_mode_type   mode = IDLE_NONE;
   int              hold_cycles = 0;

   cobs_frame_encoder #(.ADDRESS_BITS(ADDR_W)) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_has_byte      (req_has_byte),
      .req_frame_end     (req_frame_end),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_write_address (rsp_write_address),
      .rsp_write_byte    (rsp_write_byte),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_overflow      (rsp_overflow),
      .rsp_last_result   (rsp_last_result),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   function bit sender_gap();
      return (mode == IDLE_SEND && $urandom_range(99) < 52) ||
             (mode == IDLE_BOTH && $urandom_range(99) < 7);
   endfunction

   function bit receiver_stall();
      return (mode == IDLE_RECV && $urandom_range(99) < 52) ||
             (mode == IDLE_BOTH && $urandom_range(99) < 7);
   endfunction

   task automatic push_word(logic [7:0] data, bit has, bit fin);
      while (sender_gap()) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= data;
      req_has_byte <= has;
      req_frame_end <= fin;
      do @(posedge clock); while (req_full);
      board.note_word(data, has, fin);
   endtask

   // Hold the sender until every predicted write has come back.
   task automatic wait_writes();
      req_push <= 1'b0;
      do @(posedge clock); while (board.pending.size() != 0);
   endtask

   task automatic drain();
      wait_writes();
      // a word with no writes may still be in flight
      repeat (8) @(posedge clock);
   endtask

   task automatic set_capacity(logic [CSR_WIDTH-1:0] cap);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= cap;
      @(posedge clock);
      board.capacity = cap;
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(int p, logic [CSR_WIDTH-1:0] cap);
      int sent, len, zero_pct;
      bit paused;
      set_capacity(cap);
      mode = idle_mode_type'(p % 4);
      if (p == 1)
         hold_cycles = 60;
      // one exact 254-byte run ends the frame with a trailing one-byte group
      if (p == 1)
         for (int i = 1; i <= 254; i++)
            push_word(8'($urandom_range(1, 255)), 1, i == 254);
      sent = 0;
      paused = 0;
      while (sent < PHASE_WORDS) begin
         if (p == 2 && !paused && sent >= PHASE_WORDS / 2) begin
            wait_writes();
            paused = 1;
         end
         case ($urandom_range(2))
            0: zero_pct = 0;
            1: zero_pct = 15;
            default: zero_pct = 50;
         endcase
         len = $urandom_range(0, 8);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 6)
               push_word(8'($urandom), 0, 0);
            push_word(($urandom_range(99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255)),
                      1, 0);
            sent++;
         end
         // leave the last frame open now and then so the next capacity hits mid frame
         if (sent >= PHASE_WORDS && $urandom_range(1) == 1)
            continue;
         if ($urandom_range(99) < 30)
            push_word(8'($urandom), 0, 1);
         else
            push_word(($urandom_range(99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255)),
                      1, 1);
         sent++;
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (reset === 1'b0) begin
            if (rsp_pop && !rsp_empty)
               board.check(rsp_write_address, rsp_write_byte, rsp_frame_done, rsp_overflow,
                           rsp_last_result);
            if (hold_cycles > 0) begin
               rsp_pop <= 1'b0;
               hold_cycles--;
            end else begin
               rsp_pop <= !receiver_stall();
            end
         end
      end
   end

   initial begin
      logic [CSR_WIDTH-1:0] caps[PHASES];
      caps = '{13'd512, 13'd4096, 13'd8191, 13'd20, 13'd3, 13'd1,
               13'd4095, 13'd300, 13'd0, 13'd64, 13'd2, 13'd9};
      board = new();
      reset <= 1'b1;
      req_push <= 1'b0;
      req_data_byte <= '0;
      req_has_byte <= 1'b0;
      req_frame_end <= 1'b0;
      rsp_pop <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset capacity: empty item, empty frame, zero and full-scale bytes
      push_word(8'h00, 0, 0);
      push_word(8'h00, 0, 1);
      push_word(8'h00, 1, 0);
      push_word(8'hFF, 1, 0);
      push_word(8'h01, 1, 0);
      push_word(8'h00, 1, 0);
      push_word(8'h00, 1, 1);
      push_word(8'hA5, 1, 1);
      push_word(8'h00, 1, 1);
      push_word(8'h7E, 1, 0);
      push_word(8'hFF, 0, 0);
      push_word(8'h00, 0, 1);
      // capacity of two: overflow at frame end, then dropped words until frame end
      set_capacity(13'd2);
      push_word(8'h00, 0, 1);
      push_word(8'h11, 1, 1);
      push_word(8'h22, 1, 0);
      push_word(8'h33, 1, 0);
      push_word(8'h44, 0, 0);
      push_word(8'h00, 0, 1);
      push_word(8'h00, 1, 1);
      // capacity below two overflows at once
      set_capacity(13'd0);
      push_word(8'h55, 1, 0);
      push_word(8'h00, 0, 1);

      for (int p = 0; p < PHASES; p++)
         run_phase(p, caps[p]);

      drain();
      repeat (8) @(posedge clock);
      if (board.failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 2 * CLOCK_HALF);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
design/cfe_pkg.sv
design/cfe_front.sv
design/cfe_queue.sv
design/cfe_back.sv
design/cobs_frame_encoder.sv
sim/cobs_frame_encoder_test.sv
